@@ sv/gdo_pkg.sv @@
`default_nettype none

package gdo_pkg;

  // Julian day numbers of 1 January 1 and 31 December 9999
  localparam logic signed [24:0] JDN_FIRST = 25'sd1721426;
  localparam logic signed [24:0] JDN_LAST  = 25'sd5373484;

  // Reciprocal constants: floor(x / D) == (x * ceil(2^S / D)) >> S for every
  // x below 2^N, with S = N + ceil(log2(D)).
  localparam int unsigned DIV100_SHIFT = 22;  // x below 2^15
  localparam logic [15:0] DIV100_MULT =
    16'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);

  localparam int unsigned DIV146097_SHIFT = 43;  // x below 2^25
  localparam logic [25:0] DIV146097_MULT =
    26'(((64'd1 << DIV146097_SHIFT) + 64'd146096) / 64'd146097);

  localparam int unsigned DIV1461001_SHIFT = 49;  // x below 2^28
  localparam logic [28:0] DIV1461001_MULT =
    29'(((64'd1 << DIV1461001_SHIFT) + 64'd1461000) / 64'd1461001);

  localparam int unsigned DIV2447_SHIFT = 27;  // x below 2^15
  localparam logic [15:0] DIV2447_MULT =
    16'(((64'd1 << DIV2447_SHIFT) + 64'd2446) / 64'd2447);

  // Days before the first of each month in a common year, January first
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // 367 * (month - 2 + 12 for January and February) / 12, January first
  localparam logic [8:0] MONTH_TERM [12] = '{
    9'd336, 9'd367, 9'd30, 9'd61, 9'd91, 9'd122,
    9'd152, 9'd183, 9'd214, 9'd244, 9'd275, 9'd305
  };

  // 2447 * j / 80: day offset of the month start in a March-based year
  localparam logic [8:0] MARCH_BASE [16] = '{
    9'd0, 9'd30, 9'd61, 9'd91, 9'd122, 9'd152, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397, 9'd428, 9'd458
  };

  typedef struct packed {
    logic [3:0]         month_in;
    logic [4:0]         day_in;
    logic [13:0]        year_in;
    logic signed [22:0] offset_days;
  } gdo_req_t;

  typedef struct packed {
    logic [22:0] day_number;
    logic [2:0]  weekday;
    logic [8:0]  year_day;
  } gdo_info_t;

  typedef struct packed {
    gdo_info_t          info;
    logic signed [24:0] shifted;
  } gdo_fwd_t;

  typedef struct packed {
    gdo_info_t  info;
    logic       oor;
    logic [7:0] n;
    logic [6:0] i;
    logic [8:0] l3;
    logic [3:0] j;
  } gdo_inv_t;

endpackage

`default_nettype wire

@@ sv/gdo_if.sv @@
`default_nettype none

interface gdo_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         month_in;
  logic [4:0]         day_in;
  logic [13:0]        year_in;
  logic signed [22:0] offset_days;

  modport source (output valid, output month_in, output day_in, output year_in,
                  output offset_days, input ready);
  modport sink (input valid, input month_in, input day_in, input year_in,
                input offset_days, output ready);
endinterface

interface gdo_rsp_if;
  logic        valid;
  logic        ready;
  logic [22:0] day_number;
  logic [2:0]  weekday;
  logic [8:0]  year_day;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [13:0] year_out;
  logic        out_of_range;

  modport source (output valid, output day_number, output weekday, output year_day,
                  output month_out, output day_out, output year_out,
                  output out_of_range, input ready);
  modport sink (input valid, input day_number, input weekday, input year_day,
                input month_out, input day_out, input year_out,
                input out_of_range, output ready);
endinterface

`default_nettype wire

@@ sv/gdo_fwd.sv @@
`default_nettype none

module gdo_fwd (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gdo_pkg::gdo_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gdo_pkg::gdo_fwd_t out_data
);

  localparam int unsigned STAGES = 4;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] load;

  always_comb begin
    load[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) vld[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (load[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 1: clamp month, look up month terms, form year sums
  logic [3:0]  m_cl;
  logic [3:0]  mi;
  logic        early;
  logic [14:0] w_next;
  logic [14:0] v_next;

  always_comb begin
    if (in_data.month_in == 4'd0) begin
      m_cl = 4'd1;
    end else if (in_data.month_in > 4'd12) begin
      m_cl = 4'd12;
    end else begin
      m_cl = in_data.month_in;
    end
    mi     = m_cl - 4'd1;
    early  = (m_cl <= 4'd2);
    w_next = 15'(in_data.year_in) + (early ? 15'd4799 : 15'd4800);
    v_next = 15'(in_data.year_in) + (early ? 15'd4899 : 15'd4900);
  end

  logic [4:0]         s1_day;
  logic [13:0]        s1_year;
  logic [14:0]        s1_w;
  logic [14:0]        s1_v;
  logic [8:0]         s1_term;
  logic [8:0]         s1_start;
  logic               s1_late;
  logic signed [22:0] s1_offset;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_day    <= in_data.day_in;
      s1_year   <= in_data.year_in;
      s1_w      <= w_next;
      s1_v      <= v_next;
      s1_term   <= gdo_pkg::MONTH_TERM[mi];
      s1_start  <= gdo_pkg::MONTH_START[mi];
      s1_late   <= !early;
      s1_offset <= in_data.offset_days;
    end
  end

  // Stage 2: the three constant multiplications
  logic [24:0] t1_prod;
  logic [30:0] q3_prod;
  logic [30:0] yq_prod;

  always_comb begin
    t1_prod = 25'(s1_w) * 25'd1461;
    q3_prod = 31'(s1_v) * 31'(gdo_pkg::DIV100_MULT);
    yq_prod = 31'(s1_year) * 31'(gdo_pkg::DIV100_MULT);
  end

  logic [4:0]         s2_day;
  logic [13:0]        s2_year;
  logic [22:0]        s2_t1;
  logic [7:0]         s2_q3;
  logic [7:0]         s2_yq;
  logic [8:0]         s2_term;
  logic [8:0]         s2_start;
  logic               s2_late;
  logic signed [22:0] s2_offset;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s2_day    <= s1_day;
      s2_year   <= s1_year;
      s2_t1     <= t1_prod[24:2];
      s2_q3     <= q3_prod[gdo_pkg::DIV100_SHIFT +: 8];
      s2_yq     <= yq_prod[gdo_pkg::DIV100_SHIFT +: 8];
      s2_term   <= s1_term;
      s2_start  <= s1_start;
      s2_late   <= s1_late;
      s2_offset <= s1_offset;
    end
  end

  // Stage 3: day number sum and ordinal day
  logic [9:0]  t3_prod;
  logic [23:0] jd_sum;
  logic [13:0] hund;
  logic        century;
  logic        leap;
  logic [8:0]  yday_next;

  always_comb begin
    t3_prod   = 10'(s2_q3) * 10'd3;
    jd_sum    = 24'(s2_day) + 24'(s2_t1) + 24'(s2_term) - 24'(t3_prod[9:2]) - 24'd32075;
    hund      = 14'(s2_yq) * 14'd100;
    century   = (s2_year == hund);
    leap      = century ? (s2_yq[1:0] == 2'd0) : (s2_year[1:0] == 2'd0);
    yday_next = s2_start + 9'(s2_late && leap) + 9'(s2_day);
  end

  logic [22:0]        s3_jd;
  logic [8:0]         s3_yday;
  logic signed [22:0] s3_offset;

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s3_jd     <= jd_sum[22:0];
      s3_yday   <= yday_next;
      s3_offset <= s2_offset;
    end
  end

  // Stage 4: weekday by octal digit sums (8 is 1 mod 7), apply offset
  logic [23:0]        jd_pad;
  logic [5:0]         dsum;
  logic [3:0]         fold1;
  logic [3:0]         fold2;
  logic [2:0]         wd_next;
  logic signed [24:0] shifted_next;

  always_comb begin
    jd_pad = {1'b0, s3_jd};
    dsum   = '0;
    for (int k = 0; k < 8; k++) begin
      dsum = dsum + 6'(jd_pad[3*k +: 3]);
    end
    fold1        = 4'(dsum[2:0]) + 4'(dsum[5:3]);
    fold2        = 4'(fold1[2:0]) + 4'(fold1[3]);
    wd_next      = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
    shifted_next = $signed({2'b00, s3_jd}) + $signed({{2{s3_offset[22]}}, s3_offset});
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      out_data.info.day_number <= s3_jd;
      out_data.info.weekday    <= wd_next;
      out_data.info.year_day   <= s3_yday;
      out_data.shifted         <= shifted_next;
    end
  end

  assign in_ready  = load[0];
  assign out_valid = vld[STAGES-1];

  a_yday_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.info.year_day <= 9'd366)
    else $error("year_day beyond 366");

endmodule

`default_nettype wire

@@ sv/gdo_inv.sv @@
`default_nettype none

module gdo_inv (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gdo_pkg::gdo_fwd_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gdo_pkg::gdo_inv_t out_data
);

  localparam int unsigned STAGES = 7;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] load;

  always_comb begin
    load[STAGES-1] = !vld[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) vld[0] <= in_valid;
      for (int k = 1; k < STAGES; k++) begin
        if (load[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 1: range check and shift of the day number
  gdo_pkg::gdo_info_t s1_info;
  logic               s1_oor;
  logic [22:0]        s1_l;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_info <= in_data.info;
      s1_oor  <= (in_data.shifted < gdo_pkg::JDN_FIRST) ||
                 (in_data.shifted > gdo_pkg::JDN_LAST);
      s1_l    <= in_data.shifted[22:0] + 23'd68569;
    end
  end

  // Stage 2: n = 4l / 146097
  logic [50:0] n_prod;

  assign n_prod = 51'({s1_l, 2'b00}) * 51'(gdo_pkg::DIV146097_MULT);

  gdo_pkg::gdo_info_t s2_info;
  logic               s2_oor;
  logic [22:0]        s2_l;
  logic [7:0]         s2_n;

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s2_info <= s1_info;
      s2_oor  <= s1_oor;
      s2_l    <= s1_l;
      s2_n    <= n_prod[gdo_pkg::DIV146097_SHIFT +: 8];
    end
  end

  // Stage 3: day within the century
  logic [24:0] cent_base;
  logic [22:0] l2_full;

  always_comb begin
    cent_base = 25'(s2_n) * 25'd146097 + 25'd3;
    l2_full   = s2_l - cent_base[24:2];
  end

  gdo_pkg::gdo_info_t s3_info;
  logic               s3_oor;
  logic [7:0]         s3_n;
  logic [15:0]        s3_l2;

  always_ff @(posedge clk) begin
    if (load[2]) begin
      s3_info <= s2_info;
      s3_oor  <= s2_oor;
      s3_n    <= s2_n;
      s3_l2   <= l2_full[15:0];
    end
  end

  // Stage 4: scale ahead of the year-in-century division
  logic [27:0] x4_next;

  assign x4_next = (28'(s3_l2) + 28'd1) * 28'd4000;

  gdo_pkg::gdo_info_t s4_info;
  logic               s4_oor;
  logic [7:0]         s4_n;
  logic [15:0]        s4_l2;
  logic [27:0]        s4_x;

  always_ff @(posedge clk) begin
    if (load[3]) begin
      s4_info <= s3_info;
      s4_oor  <= s3_oor;
      s4_n    <= s3_n;
      s4_l2   <= s3_l2;
      s4_x    <= x4_next;
    end
  end

  // Stage 5: i = x / 1461001
  logic [56:0] i_prod;

  assign i_prod = 57'(s4_x) * 57'(gdo_pkg::DIV1461001_MULT);

  gdo_pkg::gdo_info_t s5_info;
  logic               s5_oor;
  logic [7:0]         s5_n;
  logic [15:0]        s5_l2;
  logic [6:0]         s5_i;

  always_ff @(posedge clk) begin
    if (load[4]) begin
      s5_info <= s4_info;
      s5_oor  <= s4_oor;
      s5_n    <= s4_n;
      s5_l2   <= s4_l2;
      s5_i    <= i_prod[gdo_pkg::DIV1461001_SHIFT +: 7];
    end
  end

  // Stage 6: day within the March-based year
  logic [17:0] yr_base;
  logic [17:0] l3_full;

  always_comb begin
    yr_base = 18'(s5_i) * 18'd1461;
    l3_full = 18'(s5_l2) - 18'(yr_base[17:2]) + 18'd31;
  end

  gdo_pkg::gdo_info_t s6_info;
  logic               s6_oor;
  logic [7:0]         s6_n;
  logic [6:0]         s6_i;
  logic [8:0]         s6_l3;

  always_ff @(posedge clk) begin
    if (load[5]) begin
      s6_info <= s5_info;
      s6_oor  <= s5_oor;
      s6_n    <= s5_n;
      s6_i    <= s5_i;
      s6_l3   <= l3_full[8:0];
    end
  end

  // Stage 7: j = 80 * l3 / 2447
  logic [14:0] x7;
  logic [30:0] j_prod;

  always_comb begin
    x7     = 15'({s6_l3, 6'b0}) + 15'({s6_l3, 4'b0});
    j_prod = 31'(x7) * 31'(gdo_pkg::DIV2447_MULT);
  end

  always_ff @(posedge clk) begin
    if (load[6]) begin
      out_data.info <= s6_info;
      out_data.oor  <= s6_oor;
      out_data.n    <= s6_n;
      out_data.i    <= s6_i;
      out_data.l3   <= s6_l3;
      out_data.j    <= j_prod[gdo_pkg::DIV2447_SHIFT +: 4];
    end
  end

  assign in_ready  = load[0];
  assign out_valid = vld[STAGES-1];

  a_month_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.oor |->
      out_data.j >= 4'd1 && out_data.j <= 4'd12 && out_data.i <= 7'd99)
    else $error("month or year index out of bounds for an in-range date");

endmodule

`default_nettype wire

@@ sv/gregorian_date_offset_unit_top.sv @@
`default_nettype none

// Converts a Gregorian date to its Julian day number (Fliegel-Van Flandern),
// reports weekday (0 Monday .. 6 Sunday) and ordinal day, adds a signed day
// offset and converts back. One request is taken every cycle while req.ready is
// high; each result passes 4 forward stages, 7 inverse stages and one output
// register, no stage more than one constant or reciprocal multiplication deep.
// Every stage has its own valid bit and takes new data when it is empty or
// moving on, so a stalled output fills the pipeline before ready drops, and
// bubbles close up. Month 0 reads as January and months above 12
// as December; a day beyond the month rolls into the next one. A shifted date
// outside 1 January 1 to 31 December 9999 sets out_of_range and returns zero
// month, day and year.
module gregorian_date_offset_unit_top (
  input  logic        clk,
  input  logic        rst,
  gdo_req_if.sink     req,
  gdo_rsp_if.source   rsp
);

  gdo_pkg::gdo_req_t req_data;
  gdo_pkg::gdo_fwd_t fwd_data;
  gdo_pkg::gdo_inv_t inv_data;
  logic              fwd_valid;
  logic              fwd_ready;
  logic              inv_valid;
  logic              inv_ready;

  always_comb begin
    req_data.month_in    = req.month_in;
    req_data.day_in      = req.day_in;
    req_data.year_in     = req.year_in;
    req_data.offset_days = req.offset_days;
  end

  gdo_fwd u_fwd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_data   (req_data),
    .out_valid (fwd_valid),
    .out_ready (fwd_ready),
    .out_data  (fwd_data)
  );

  gdo_inv u_inv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fwd_valid),
    .in_ready  (fwd_ready),
    .in_data   (fwd_data),
    .out_valid (inv_valid),
    .out_ready (inv_ready),
    .out_data  (inv_data)
  );

  // Final stage: day, month and year, zeroed when out of range
  logic       late_year;
  logic [8:0] day_full;
  logic [3:0] month_next;
  logic [4:0] day_next;
  logic [13:0] year_next;
  logic       out_vld;

  always_comb begin
    late_year  = (inv_data.j >= 4'd11);
    day_full   = inv_data.l3 - gdo_pkg::MARCH_BASE[inv_data.j];
    month_next = late_year ? (inv_data.j - 4'd10) : (inv_data.j + 4'd2);
    day_next   = day_full[4:0];
    year_next  = 14'(inv_data.n - 8'd49) * 14'd100 + 14'(inv_data.i) + 14'(late_year);
  end

  assign inv_ready = !out_vld || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (inv_ready) begin
      out_vld <= inv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (inv_ready) begin
      rsp.day_number   <= inv_data.info.day_number;
      rsp.weekday      <= inv_data.info.weekday;
      rsp.year_day     <= inv_data.info.year_day;
      rsp.out_of_range <= inv_data.oor;
      rsp.month_out    <= inv_data.oor ? 4'd0 : month_next;
      rsp.day_out      <= inv_data.oor ? 5'd0 : day_next;
      rsp.year_out     <= inv_data.oor ? 14'd0 : year_next;
    end
  end

  assign rsp.valid = out_vld;

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.out_of_range |->
      rsp.month_out == 4'd0 && rsp.day_out == 5'd0 && rsp.year_out == 14'd0)
    else $error("out-of-range result carries a date");

  a_date_legal: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.out_of_range |->
      rsp.month_out >= 4'd1 && rsp.month_out <= 4'd12 && rsp.day_out >= 5'd1 &&
      rsp.year_out >= 14'd1 && rsp.year_out <= 14'd9999)
    else $error("in-range result is not a legal date");

  a_weekday: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.weekday <= 3'd6)
    else $error("weekday code above Sunday");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    gdo_pkg::gdo_info_t info;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [13:0] year_out;
    logic        out_of_range;
  } date_result_t;

  typedef struct packed {
    gdo_pkg::gdo_req_t req;
    logic         known;
    date_result_t result;
  } date_row_t;

  localparam int RANDOM_REQUESTS = 650;
  localparam int DIRECTED_ROWS = 24;
  localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic clk = 1'b0;
  logic rst;

  gdo_req_if req_ch ();
  gdo_rsp_if rsp_ch ();

  gregorian_date_offset_unit_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #1 clk = ~clk;

  date_result_t pending_dates [$];
  date_row_t    directed_rows [DIRECTED_ROWS];
  int           mismatch_count = 0;
  int           burst_left = 0;
  logic [9:0]   stall_tick = '0;

  function automatic bit leap_year(longint yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // Fliegel-Van Flandern forward and inverse conversion around the offset
  function automatic date_result_t shift_date(gdo_pkg::gdo_req_t r);
    longint mo, dy, yr, off, jd, sh, a, l, n, i, j, k, ydays;
    date_result_t res;
    mo = r.month_in;
    dy = r.day_in;
    yr = r.year_in;
    off = {{41{r.offset_days[22]}}, r.offset_days};
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    a = (mo - 14) / 12;
    jd = dy - 32075 + 1461 * (yr + 4800 + a) / 4 + 367 * (mo - 2 - a * 12) / 12
         - 3 * ((yr + 4900 + a) / 100) / 4;
    ydays = dy;
    for (int m = 0; m < mo - 1; m++) ydays += DAYS_IN_MONTH[m];
    if (leap_year(yr) && mo > 2) ydays += 1;
    res = '0;
    res.info.day_number = jd[22:0];
    res.info.weekday = 3'(jd % 7);
    res.info.year_day = ydays[8:0];
    sh = jd + off;
    if (sh < gdo_pkg::JDN_FIRST || sh > gdo_pkg::JDN_LAST) begin
      res.out_of_range = 1'b1;
    end else begin
      l = sh + 68569;
      n = 4 * l / 146097;
      l = l - (146097 * n + 3) / 4;
      i = 4000 * (l + 1) / 1461001;
      l = l - 1461 * i / 4 + 31;
      j = 80 * l / 2447;
      k = l - 2447 * j / 80;
      l = j / 11;
      j = j + 2 - 12 * l;
      res.year_out = 14'(100 * (n - 49) + i + l);
      res.month_out = 4'(j);
      res.day_out = 5'(k);
    end
    return res;
  endfunction

  function automatic date_row_t pick(int m, int d, int y, int off);
    date_row_t row;
    row = '0;
    row.req.month_in = 4'(m);
    row.req.day_in = 5'(d);
    row.req.year_in = 14'(y);
    row.req.offset_days = 23'(off);
    return row;
  endfunction

  function automatic date_row_t golden(int m, int d, int y, int off, int dn, int wd, int yd,
                                       int mo, int dy, int yr, int oor);
    date_row_t row;
    row = pick(m, d, y, off);
    row.known = 1'b1;
    row.result.info.day_number = 23'(dn);
    row.result.info.weekday = 3'(wd);
    row.result.info.year_day = 9'(yd);
    row.result.month_out = 4'(mo);
    row.result.day_out = 5'(dy);
    row.result.year_out = 14'(yr);
    row.result.out_of_range = oor[0];
    return row;
  endfunction

  function automatic gdo_pkg::gdo_req_t random_request();
    gdo_pkg::gdo_req_t r;
    date_result_t      base;
    int                mlen, off;
    longint            jd, target;
    r = '0;
    case ($urandom_range(0, 9))
      8: r.year_in = ($urandom_range(0, 1) != 0) ? 14'($urandom_range(1, 3))
                                                 : 14'($urandom_range(9997, 9999));
      9: r.year_in = 14'($urandom_range(0, 16383));
      default: r.year_in = 14'($urandom_range(1, 9999));
    endcase
    r.month_in = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 12));
    if (r.month_in >= 1 && r.month_in <= 12) begin
      mlen = DAYS_IN_MONTH[r.month_in - 1];
      if (r.month_in == 2 && leap_year(r.year_in)) mlen++;
    end else begin
      mlen = 31;
    end
    r.day_in = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(1, mlen));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r.offset_days = 23'(int'($urandom_range(0, 800)) - 400);
      4, 5, 6:    r.offset_days = 23'(int'($urandom_range(0, 80000)) - 40000);
      7, 8:       r.offset_days = 23'($urandom);
      default: begin
        // aim just inside or outside the first or last representable day
        r.offset_days = '0;
        base = shift_date(r);
        jd = base.info.day_number;
        target = (($urandom_range(0, 1) != 0) ? gdo_pkg::JDN_FIRST : gdo_pkg::JDN_LAST)
                 + longint'($urandom_range(0, 6)) - 3;
        off = int'(target - jd);
        if (off >= -4194304 && off <= 4194303) r.offset_days = 23'(off);
        else r.offset_days = 23'($urandom);
      end
    endcase
    return r;
  endfunction

  // Present one request at the current falling edge, hold until taken
  task automatic send_request(gdo_pkg::gdo_req_t r, date_result_t want);
    req_ch.valid <= 1'b1;
    req_ch.month_in <= r.month_in;
    req_ch.day_in <= r.day_in;
    req_ch.year_in <= r.year_in;
    req_ch.offset_days <= r.offset_days;
    pending_dates.push_back(want);
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 6);
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver stall pattern: always ready, alternate, random, long stalls
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[9:8])
      2'd0: rsp_ch.ready <= 1'b1;
      2'd1: rsp_ch.ready <= stall_tick[0];
      2'd2: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      default: rsp_ch.ready <= (stall_tick[5:3] != 3'd0);
    endcase
  end

  always @(posedge clk) begin
    date_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: result with no request outstanding, day_number %0d", $time,
                 rsp_ch.day_number);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        check_field("day_number", want.info.day_number, rsp_ch.day_number);
        check_field("weekday", want.info.weekday, rsp_ch.weekday);
        check_field("year_day", want.info.year_day, rsp_ch.year_day);
        check_field("month_out", want.month_out, rsp_ch.month_out);
        check_field("day_out", want.day_out, rsp_ch.day_out);
        check_field("year_out", want.year_out, rsp_ch.year_out);
        check_field("out_of_range", want.out_of_range, rsp_ch.out_of_range);
      end
    end
  end

  initial begin
    gdo_pkg::gdo_req_t r;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.month_in = '0;
    req_ch.day_in = '0;
    req_ch.year_in = '0;
    req_ch.offset_days = '0;
    rsp_ch.ready = 1'b0;
    directed_rows = '{
      golden(1, 1, 1, 0, 1721426, 0, 1, 1, 1, 1, 0),
      golden(12, 31, 9999, 0, 5373484, 4, 365, 12, 31, 9999, 0),
      golden(1, 1, 1, -1, 1721426, 0, 1, 0, 0, 0, 1),
      golden(12, 31, 9999, 1, 5373484, 4, 365, 0, 0, 0, 1),
      golden(1, 1, 1, 3652058, 1721426, 0, 1, 12, 31, 9999, 0),
      golden(12, 31, 9999, -3652058, 5373484, 4, 365, 1, 1, 1, 0),
      golden(1, 1, 1, 4194303, 1721426, 0, 1, 0, 0, 0, 1),
      golden(12, 31, 9999, -4194304, 5373484, 4, 365, 0, 0, 0, 1),
      pick(0, 15, 2000, 0),
      pick(15, 31, 9999, 0),
      pick(13, 1, 2024, 100),
      pick(3, 0, 2024, 0),
      pick(2, 31, 2023, 0),
      pick(4, 31, 2100, -59),
      pick(1, 1, 0, 0),
      pick(12, 31, 0, 1),
      pick(15, 31, 16383, -4194304),
      pick(2, 29, 2024, 1),
      pick(2, 29, 2023, 0),
      pick(1, 0, 2023, 0),
      pick(12, 31, 2000, 0),
      pick(3, 1, 1600, -1),
      pick(3, 1, 1900, -1),
      pick(10, 15, 1582, -10)
    };
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].req, directed_rows[k].known ? directed_rows[k].result
                                                                : shift_date(directed_rows[k].req));
    end
    repeat (RANDOM_REQUESTS) begin
      r = random_request();
      send_request(r, shift_date(r));
    end
    req_ch.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
